@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros: shared assertion shorthands for the rigid body integrator
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rbi_pkg.sv @@
// ----------------------------------------------------------------------------
// rbi_pkg: shared types and fixed-point helpers
// Body record, result word, register codes and Q16.16 multiply/saturate.
// ----------------------------------------------------------------------------
`default_nettype none

package rbi_pkg;

    // body kinds
    localparam logic [1:0] KIND_STATIC    = 2'd0;
    localparam logic [1:0] KIND_DYNAMIC   = 2'd1;
    localparam logic [1:0] KIND_KINEMATIC = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_GRAVITY_X = 2'd0;
    localparam logic [1:0] CFG_GRAVITY_Y = 2'd1;
    localparam logic [1:0] CFG_TIME_STEP = 2'd2;

    localparam logic [15:0] TIME_STEP_RESET = 16'd1092;
    localparam logic [16:0] Q_ONE           = 17'h10000;
    localparam logic [23:0] FD_MAX          = 24'h010000;

    typedef logic signed [31:0] t_q;
    typedef logic signed [47:0] t_qprod;

    localparam t_q Q_MAX = 32'sh7fffffff;
    localparam t_q Q_MIN = 32'sh80000000;

    typedef struct packed {
        logic [1:0]  body_kind;
        t_q          pos_x;
        t_q          pos_y;
        t_q          vel_x;
        t_q          vel_y;
        t_q          impulse_x;
        t_q          impulse_y;
        t_q          force_x;
        t_q          force_y;
        logic [31:0] body_mass;
        logic [31:0] inv_mass;
        logic [23:0] friction_rate;
    } t_body;

    typedef struct packed {
        t_q new_pos_x;
        t_q new_pos_y;
        t_q new_vel_x;
        t_q new_vel_y;
    } t_result;

    typedef struct packed {
        logic [1:0]  reg_index;
        logic [31:0] reg_data;
    } t_cfg_wr;

    typedef struct packed {
        t_q          gravity_x;
        t_q          gravity_y;
        logic [15:0] time_step;
    } t_cfg;

    // record passed from the velocity unit to the position unit
    typedef struct packed {
        logic [1:0]  kind;
        t_q          pos_x;
        t_q          pos_y;
        t_q          vel_x;
        t_q          vel_y;
        logic [16:0] factor;
    } t_mid;

    // signed q16.16 times unsigned operand, floored back to q16.16 (48 bits kept)
    function automatic t_qprod mul_q(input t_q a, input logic [31:0] b);
        logic signed [64:0] p;
        p = $signed({a[31], a}) * $signed({1'b0, b});
        return p[63:16];
    endfunction

    // saturate a 49-bit value to signed 32
    function automatic t_q sat_q(input logic [48:0] v);
        if (v[48:31] == {18{v[48]}}) begin
            return v[31:0];
        end else if (v[48]) begin
            return Q_MIN;
        end else begin
            return Q_MAX;
        end
    endfunction

    // a plus floored product, saturated
    function automatic t_q add_q(input t_q a, input t_qprod p);
        return sat_q({{17{a[31]}}, a} + {p[47], p});
    endfunction

    // floored product alone, saturated
    function automatic t_q shr_q(input t_qprod p);
        return sat_q({p[47], p});
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rbi_if.sv @@
// ----------------------------------------------------------------------------
// rbi_if: valid/ready channels of the integrator
// Body input channel, result output channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbi_body_if import rbi_pkg::*; ();
    logic  valid;
    logic  ready;
    t_body data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rbi_result_if import rbi_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rbi_cfg_if import rbi_pkg::*; ();
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rbi_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rbi_cfg_regs: gravity and time step registers
// Decodes register writes; values feed the pipeline directly.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rbi_cfg_regs import rbi_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr_valid,
    input  wire t_cfg_wr i_wr,
    output t_cfg         o_cfg
);

    t_cfg r_cfg;

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity_x <= '0;
            r_cfg.gravity_y <= '0;
            r_cfg.time_step <= TIME_STEP_RESET;
        end else if (i_wr_valid) begin
            unique case (i_wr.reg_index)
                CFG_GRAVITY_X: r_cfg.gravity_x <= i_wr.reg_data;
                CFG_GRAVITY_Y: r_cfg.gravity_y <= i_wr.reg_data;
                CFG_TIME_STEP: r_cfg.time_step <= i_wr.reg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    `ASSERT_NEXT(a_dt_write, i_clk, i_rst_n, i_wr_valid && (i_wr.reg_index == CFG_TIME_STEP), r_cfg.time_step == $past(i_wr.reg_data[15:0]), "time step write lost")

endmodule

`default_nettype wire

@@ hw/rtl/rbi_vel_unit.sv @@
// ----------------------------------------------------------------------------
// rbi_vel_unit: velocity update pipeline, five stages
// Impulse, gravity force, acceleration and force step; friction factor.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rbi_vel_unit import rbi_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_body i_body,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_mid       o_mid
);

    localparam int unsigned NSTG = 5;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    logic [31:0] dt32;
    logic [39:0] fric_prod;
    logic        moving0;

    // stage 0 registers
    logic [1:0]  r0_kind;
    t_q          r0_pos_x, r0_pos_y, r0_vel_x, r0_vel_y;
    t_q          r0_force_x, r0_force_y;
    logic [31:0] r0_inv_mass;
    t_qprod      r0_pi_x, r0_pi_y, r0_pg_x, r0_pg_y;
    logic [23:0] r0_fd;

    // stage 1..4 registers
    t_mid        r1_mid, r2_mid, r3_mid, r4_mid;
    t_q          r1_force_x, r1_force_y;
    logic [31:0] r1_inv_mass;
    t_qprod      r2_pa_x, r2_pa_y;
    t_qprod      r3_pad_x, r3_pad_y;
    t_mid        n_mid4;

    assign dt32      = {16'd0, i_cfg.time_step};
    assign fric_prod = i_body.friction_rate * i_cfg.time_step;

    // stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_ready = en[0];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // stage 0: impulse and gravity products, friction times dt
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_kind     <= i_body.body_kind;
            r0_pos_x    <= i_body.pos_x;
            r0_pos_y    <= i_body.pos_y;
            r0_vel_x    <= i_body.vel_x;
            r0_vel_y    <= i_body.vel_y;
            r0_force_x  <= i_body.force_x;
            r0_force_y  <= i_body.force_y;
            r0_inv_mass <= i_body.inv_mass;
            r0_pi_x     <= mul_q(i_body.impulse_x, i_body.inv_mass);
            r0_pi_y     <= mul_q(i_body.impulse_y, i_body.inv_mass);
            r0_pg_x     <= mul_q(i_cfg.gravity_x, i_body.body_mass);
            r0_pg_y     <= mul_q(i_cfg.gravity_y, i_body.body_mass);
            r0_fd       <= fric_prod[39:16];
        end
    end

    assign moving0 = (r0_kind == KIND_DYNAMIC) || (r0_kind == KIND_KINEMATIC);

    // stage 1: apply impulse, add gravity to force, friction factor
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_mid.kind   <= r0_kind;
            r1_mid.pos_x  <= r0_pos_x;
            r1_mid.pos_y  <= r0_pos_y;
            r1_mid.vel_x  <= moving0 ? add_q(r0_vel_x, r0_pi_x) : r0_vel_x;
            r1_mid.vel_y  <= moving0 ? add_q(r0_vel_y, r0_pi_y) : r0_vel_y;
            r1_mid.factor <= (r0_fd > FD_MAX) ? '0 : (Q_ONE - r0_fd[16:0]);
            r1_force_x    <= add_q(r0_force_x, r0_pg_x);
            r1_force_y    <= add_q(r0_force_y, r0_pg_y);
            r1_inv_mass   <= r0_inv_mass;
        end
    end

    // stage 2: force times inverse mass
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_mid  <= r1_mid;
            r2_pa_x <= mul_q(r1_force_x, r1_inv_mass);
            r2_pa_y <= mul_q(r1_force_y, r1_inv_mass);
        end
    end

    // stage 3: saturated acceleration times dt
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_mid   <= r2_mid;
            r3_pad_x <= mul_q(shr_q(r2_pa_x), dt32);
            r3_pad_y <= mul_q(shr_q(r2_pa_y), dt32);
        end
    end

    // stage 4: dynamic bodies take the force step
    always_comb begin
        n_mid4 = r3_mid;
        if (r3_mid.kind == KIND_DYNAMIC) begin
            n_mid4.vel_x = add_q(r3_mid.vel_x, r3_pad_x);
            n_mid4.vel_y = add_q(r3_mid.vel_y, r3_pad_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_mid <= n_mid4;
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_mid   = r4_mid;

    `ASSERT_IMPL(a_factor_range, i_clk, i_rst_n, r_vld[1], r1_mid.factor <= Q_ONE, "friction factor above one")
    `ASSERT_NEXT(a_vel_hold, i_clk, i_rst_n, r_vld[NSTG-1] && !i_ready, r_vld[NSTG-1] && $stable(r4_mid), "stalled word dropped")

endmodule

`default_nettype wire

@@ hw/rtl/rbi_pos_unit.sv @@
// ----------------------------------------------------------------------------
// rbi_pos_unit: friction and position pipeline, three stages
// Scales horizontal velocity by the friction factor and advances position.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rbi_pos_unit import rbi_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_mid i_mid,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_result   o_result
);

    localparam int unsigned NSTG = 3;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    logic [31:0] dt32;
    logic        moving1;

    t_mid    r0_mid;
    t_qprod  r0_pf;
    t_mid    r1_mid;
    t_mid    n_mid1;
    t_qprod  r1_pp_x, r1_pp_y;
    t_result r_res;
    t_result n_res;

    assign dt32 = {16'd0, i_cfg.time_step};

    // stage enables
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_ready = en[0];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // stage 0: horizontal velocity times friction factor
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_mid <= i_mid;
            r0_pf  <= mul_q(i_mid.vel_x, {15'd0, i_mid.factor});
        end
    end

    // stage 1: apply friction to dynamic bodies, velocity times dt
    always_comb begin
        n_mid1 = r0_mid;
        if (r0_mid.kind == KIND_DYNAMIC) begin
            n_mid1.vel_x = shr_q(r0_pf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_mid  <= n_mid1;
            r1_pp_x <= mul_q(n_mid1.vel_x, dt32);
            r1_pp_y <= mul_q(n_mid1.vel_y, dt32);
        end
    end

    // stage 2: advance position of moving bodies, output register
    assign moving1 = (r1_mid.kind == KIND_DYNAMIC) || (r1_mid.kind == KIND_KINEMATIC);

    always_comb begin
        n_res.new_pos_x = moving1 ? add_q(r1_mid.pos_x, r1_pp_x) : r1_mid.pos_x;
        n_res.new_pos_y = moving1 ? add_q(r1_mid.pos_y, r1_pp_y) : r1_mid.pos_y;
        n_res.new_vel_x = r1_mid.vel_x;
        n_res.new_vel_y = r1_mid.vel_y;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_vld[NSTG-1];
    assign o_result = r_res;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_vld[NSTG-1] && !i_ready, r_vld[NSTG-1] && $stable(r_res), "stalled result dropped")

endmodule

`default_nettype wire

@@ hw/rtl/rigid_body_integrator_top.sv @@
// ----------------------------------------------------------------------------
// rigid_body_integrator_top: 2D semi-implicit euler step in q16.16
// Usage:
//   i_body   takes one body record per word (kind, position, velocity,
//            impulse, force, mass, inverse mass, friction).
//   o_result returns one word per body: new position and new velocity,
//            saturated to signed q16.16, in input order.
//   i_cfg    writes gravity x (0), gravity y (1) and time step (2); it is
//            always ready. Write only while no body is in flight.
// Results pass through five registered stages of velocity update and
// three of friction and position, each stage holding at most one multiply
// level. Throughput is one body per cycle while o_result is not stalled.
// Reset clears all pipeline valid bits, sets gravity to zero and the time
// step to 1092 (about 1/60 s).
// When the receiver stalls, each stage holds its word and bubbles in front
// of it close up; the pipeline keeps taking bodies until it is full, then
// i_body.ready drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module rigid_body_integrator_top import rbi_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    rbi_cfg_if.sink       i_cfg,
    rbi_body_if.sink      i_body,
    rbi_result_if.source  o_result
);

    t_cfg cfg;
    logic mid_valid;
    logic mid_ready;
    t_mid mid;

    // register writes never stall
    assign i_cfg.ready = 1'b1;

    rbi_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr       (i_cfg.data),
        .o_cfg      (cfg)
    );

    // velocity update
    rbi_vel_unit u_vel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_body.valid),
        .o_ready (i_body.ready),
        .i_body  (i_body.data),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_mid   (mid)
    );

    // friction and position
    rbi_pos_unit u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (mid_valid),
        .o_ready  (mid_ready),
        .i_mid    (mid),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (o_result.data)
    );

endmodule

`default_nettype wire
